@@ rtl/tbpc_pkg.sv @@
// Shared types and constants for the two-button panel controller.
package tbpc_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_SETUP = 2'd2
  } cmd_t;

  localparam int BOWL_MODES_DEF = 3;
  localparam int ARM_MODES_DEF  = 3;

  localparam logic [15:0] HOLD_TICKS_RESET = 16'd2000;
  localparam logic [15:0] HOLD_MAX         = 16'hFFFF;

  localparam logic [7:0] LED_BLINK = 8'h55;
  localparam logic [7:0] LED_ON    = 8'hFF;
  localparam logic [7:0] LED_OFF   = 8'h00;

  localparam logic [2:0] SEL_BOWL  = 3'd0;
  localparam logic [2:0] SEL_ARM   = 3'd1;
  localparam logic [2:0] SEL_DOSE  = 3'd2;
  localparam logic [2:0] SEL_PUMP  = 3'd3;
  localparam logic [2:0] SEL_DRYER = 3'd4;
  localparam logic [2:0] SEL_WATER = 3'd5;

  typedef struct packed {
    logic       beep;
    logic       lock_led_write;
    logic [7:0] lock_led_pattern;
    logic       lock_led_mode;
    logic [2:0] select_leds;
    logic       drive_write;
    logic [2:0] drive_which;
    logic [1:0] drive_value;
  } result_t;

endpackage

@@ rtl/two_button_panel_controller.sv @@
// Two-button panel controller: button classification, lock and actuator settings.
//
// The input channel carries one event per transfer: a time tick, or a press or
// release edge of the start or setup button. Every accepted event yields exactly
// one result transfer on the output channel, in order.
// The event is decoded and all state is updated in the cycle of the transfer; the
// result lands in the output register, or in the skid register while the output
// is stalled. One event can be taken every cycle while in_stall is low.
// A skid register behind the output register absorbs one result when the
// receiver stalls, so an event can still be taken in that cycle; in_stall rises
// only while the skid register is full and clears once the receiver takes data.
// hold_ticks is written through cfg_we and cfg_data; the user does so only while
// the block is idle, which the block does not enforce. A synchronous reset clears
// both buttons, the chord and lock flags, the hold counter, the selection and all
// settings, sets hold_ticks to 2000 and empties the output and skid registers.
module two_button_panel_controller #(
  parameter int BOWL_MODES = tbpc_pkg::BOWL_MODES_DEF,
  parameter int ARM_MODES  = tbpc_pkg::ARM_MODES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic        released,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        beep,
  output logic        lock_led_write,
  output logic [7:0]  lock_led_pattern,
  output logic        lock_led_mode,
  output logic [2:0]  select_leds,
  output logic        drive_write,
  output logic [2:0]  drive_which,
  output logic [1:0]  drive_value
);
  import tbpc_pkg::*;

  localparam logic [2:0] BOWL_LIM = 3'(BOWL_MODES);
  localparam logic [2:0] ARM_LIM  = 3'(ARM_MODES);

  logic [15:0] hold_ticks;
  logic        start_down, start_down_next;
  logic        setup_down, setup_down_next;
  logic        chord_active, chord_active_next;
  logic        panel_locked, panel_locked_next;
  logic [15:0] hold_elapsed, hold_elapsed_next;
  logic [2:0]  selected_actuator, selected_actuator_next;
  logic [1:0]  bowl_setting, bowl_setting_next;
  logic [1:0]  arm_setting, arm_setting_next;
  logic [3:0]  onoff_settings, onoff_settings_next;

  result_t res_next;
  result_t out_res;
  result_t skid_res;
  logic    skid_valid;
  logic    accept;
  logic    out_take;

  logic       is_start;
  logic       other_down;
  logic       is_long;
  logic [2:0] bowl_inc;
  logic [2:0] arm_inc;
  logic [1:0] onoff_idx;
  logic [3:0] onoff_toggled;

  assign accept   = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign in_stall = skid_valid;

  assign is_start   = (command == CMD_START);
  assign other_down = is_start ? setup_down : start_down;
  assign is_long    = (hold_elapsed >= hold_ticks);
  assign bowl_inc   = {1'b0, bowl_setting} + 3'd1;
  assign arm_inc    = {1'b0, arm_setting} + 3'd1;
  assign onoff_idx  = 2'(selected_actuator - SEL_DOSE);
  assign onoff_toggled = onoff_settings ^ (4'b0001 << onoff_idx);

  always_comb begin
    start_down_next        = start_down;
    setup_down_next        = setup_down;
    chord_active_next      = chord_active;
    panel_locked_next      = panel_locked;
    hold_elapsed_next      = hold_elapsed;
    selected_actuator_next = selected_actuator;
    bowl_setting_next      = bowl_setting;
    arm_setting_next       = arm_setting;
    onoff_settings_next    = onoff_settings;
    res_next               = '0;

    unique case (cmd_t'(command))
      CMD_TICK: begin
        if (hold_elapsed != HOLD_MAX) begin
          hold_elapsed_next = hold_elapsed + 16'd1;
        end
      end
      CMD_START, CMD_SETUP: begin
        if (is_start) begin
          start_down_next = !released;
        end else begin
          setup_down_next = !released;
        end
        if (!released) begin
          hold_elapsed_next = '0;
          if (other_down) begin
            chord_active_next = 1'b1;
          end
          if (!panel_locked) begin
            res_next.beep = 1'b1;
          end else begin
            res_next.lock_led_write   = 1'b1;
            res_next.lock_led_pattern = LED_BLINK;
            res_next.lock_led_mode    = 1'b1;
          end
        end else if (!chord_active) begin
          if (panel_locked) begin
            res_next.lock_led_write   = 1'b1;
            res_next.lock_led_pattern = LED_ON;
            res_next.lock_led_mode    = 1'b1;
          end else if (!is_long) begin
            if (!is_start) begin
              selected_actuator_next = (selected_actuator >= SEL_WATER) ?
                                       SEL_BOWL : selected_actuator + 3'd1;
            end else begin
              res_next.drive_which = selected_actuator;
              priority if (selected_actuator == SEL_BOWL) begin
                bowl_setting_next    = (bowl_inc >= BOWL_LIM) ? 2'd0 : bowl_inc[1:0];
                res_next.drive_write = 1'b1;
                res_next.drive_value = bowl_setting_next;
              end else if (selected_actuator == SEL_ARM) begin
                arm_setting_next     = (arm_inc >= ARM_LIM) ? 2'd0 : arm_inc[1:0];
                res_next.drive_write = 1'b1;
                res_next.drive_value = arm_setting_next;
              end else if (selected_actuator <= SEL_WATER) begin
                onoff_settings_next  = onoff_toggled;
                res_next.drive_write = 1'b1;
                res_next.drive_value = {1'b0, onoff_toggled[onoff_idx]};
              end else begin
                res_next.drive_which = SEL_BOWL;
              end
            end
          end
        end else if (!other_down) begin
          if (is_long) begin
            panel_locked_next         = !panel_locked;
            res_next.lock_led_write   = 1'b1;
            res_next.lock_led_pattern = panel_locked ? LED_OFF : LED_ON;
            res_next.lock_led_mode    = !panel_locked;
          end else if (panel_locked) begin
            res_next.lock_led_write   = 1'b1;
            res_next.lock_led_pattern = LED_ON;
            res_next.lock_led_mode    = 1'b1;
          end
          chord_active_next = 1'b0;
        end
      end
      default: begin
      end
    endcase

    res_next.select_leds = selected_actuator_next + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ticks <= HOLD_TICKS_RESET;
    end else if (cfg_we) begin
      hold_ticks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_down        <= 1'b0;
      setup_down        <= 1'b0;
      chord_active      <= 1'b0;
      panel_locked      <= 1'b0;
      hold_elapsed      <= '0;
      selected_actuator <= SEL_BOWL;
      bowl_setting      <= '0;
      arm_setting       <= '0;
      onoff_settings    <= '0;
    end else if (accept) begin
      start_down        <= start_down_next;
      setup_down        <= setup_down_next;
      chord_active      <= chord_active_next;
      panel_locked      <= panel_locked_next;
      hold_elapsed      <= hold_elapsed_next;
      selected_actuator <= selected_actuator_next;
      bowl_setting      <= bowl_setting_next;
      arm_setting       <= arm_setting_next;
      onoff_settings    <= onoff_settings_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || out_take) begin
        out_valid  <= skid_valid || accept;
        skid_valid <= 1'b0;
      end else if (accept) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_take) begin
      out_res <= skid_valid ? skid_res : res_next;
    end
    if (accept && out_valid && out_stall) begin
      skid_res <= res_next;
    end
  end

  assign beep             = out_res.beep;
  assign lock_led_write   = out_res.lock_led_write;
  assign lock_led_pattern = out_res.lock_led_pattern;
  assign lock_led_mode    = out_res.lock_led_mode;
  assign select_leds      = out_res.select_leds;
  assign drive_write      = out_res.drive_write;
  assign drive_which      = out_res.drive_which;
  assign drive_value      = out_res.drive_value;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while output register empty");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted event produced no result");

  a_lock_only_on_accept: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(panel_locked))
    else $error("lock flag changed without a transfer");

  a_beep_excludes_led: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(beep && lock_led_write))
    else $error("beep and lock LED update in the same result");

endmodule
